@@ src/emoji_space_padder_top_defines.svh @@
// Assertion macros for the emoji space padder top level.
`ifndef EMOJI_SPACE_PADDER_TOP_DEFINES_SVH
`define EMOJI_SPACE_PADDER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Checked on every clock edge outside reset
`define ESP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Checked on every clock edge, reset included
`define ESP_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ESP_ASSERT(lbl, prop, msg)
`define ESP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ src/esp_pkg.sv @@
// Package for the emoji space padder: byte codes, result types and helpers.
package esp_pkg;

	// Most bytes one input byte can give rise to
	localparam int MaxOut = 5;
	localparam int CntW   = $clog2(MaxOut + 1);

	// Byte codes
	localparam logic [7:0] SpaceByte = 8'h20;
	localparam logic [7:0] LeadF0    = 8'hF0;
	localparam logic [7:0] Lead9F    = 8'h9F;
	localparam logic [7:0] LeadE2    = 8'hE2;
	localparam logic [7:0] SymLo     = 8'h98;
	localparam logic [7:0] SymHi     = 8'h9E;
	localparam logic [7:0] VsEF      = 8'hEF;
	localparam logic [7:0] VsB8      = 8'hB8;
	localparam logic [7:0] Vs8E      = 8'h8E;
	localparam logic [7:0] Vs8F      = 8'h8F;
	localparam logic [7:0] ContMask  = 8'hC0;
	localparam logic [7:0] ContVal   = 8'h80;

	// Bytes produced for one input byte, first byte in slot 0
	typedef struct packed {
		logic [MaxOut-1:0][7:0] bytes;
		logic [CntW-1:0]        count;
		logic                   last;
	} esp_result_t;

	// Running emit list while one byte is worked through
	typedef struct packed {
		logic [MaxOut-1:0][7:0] bytes;
		logic [CntW-1:0]        n;
		logic                   pons;
	} emit_t;

	function automatic logic is_cont(logic [7:0] b);
		return (b & ContMask) == ContVal;
	endfunction

	function automatic logic is_lead(logic [7:0] b);
		return (b == LeadF0) || (b == LeadE2);
	endfunction

	// Append one byte to the emit list and note whether it is a non-space
	function automatic emit_t emit_put(emit_t e, logic [7:0] b);
		emit_t r;
		r = e;
		if (r.n < CntW'(MaxOut)) begin
			r.bytes[r.n] = b;
			r.n = r.n + CntW'(1);
		end
		r.pons = (b != SpaceByte);
		return r;
	endfunction

endpackage

@@ src/emoji_space_padder_top.sv @@
// Top level of the emoji space padder.
//
// Passes a UTF-8 byte stream through and puts single spaces around emoji
// sequences (F0 9F xx xx, or E2 98..9E xx, each with any trailing EF B8 8E/8F
// variation selectors). A transfer with tlast ends the text: held bytes are
// flushed, the final output byte carries tlast and the matcher starts afresh.
// Input bytes pass an input register, then the matcher logic into a 5-byte
// result register that sends one byte per cycle while m_tready is high. One
// input transfer is taken per cycle while each byte gives at most one output
// byte and the output is not stalled; a byte that gives more output bytes holds
// the input until the single-byte output port has drained the result register.
`include "emoji_space_padder_top_defines.svh"

module emoji_space_padder_top import esp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,    // data_byte[7:0]
	input  logic       s_tlast,    // end_of_text
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,    // out_byte[7:0]
	output logic       m_tlast     // out_last
);

	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        last_s1;
	logic        can_load;
	logic        advance;
	esp_result_t res;

	assign advance  = valid_s1 && can_load;
	assign s_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			data_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	esp_scan u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.data_byte   (data_s1),
		.end_of_text (last_s1),
		.res         (res)
	);

	esp_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance),
		.res      (res),
		.can_load (can_load),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// Checks
	`ESP_ASSERT(a_end_emits, advance && last_s1 |-> res.count != '0, "end of text gave no byte")
	`ESP_ASSERT(a_load_shows, advance && res.count != '0 |=> m_tvalid, "loaded result not offered")
	`ESP_ASSERT(a_s1_holds, valid_s1 && !advance |=> valid_s1 && $stable(data_s1), "stalled byte lost")
	`ESP_ASSERT_ALWAYS(a_rst_quiet, !arst_n |=> !m_tvalid && !valid_s1, "activity under reset")

endmodule

@@ src/esp_scan.sv @@
// Emoji matcher: match state and the bytes each input byte produces.
module esp_scan import esp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        advance,   // the byte in the input register moves on
	input  logic [7:0]  data_byte,
	input  logic        end_of_text,
	output esp_result_t res
);

	logic [7:0] held_q [3];
	logic [1:0] hc_q;
	logic       aseq_q;
	logic       pons_q;

	logic [7:0] held_d [3];
	logic [1:0] hc_d;
	logic       aseq_d;
	logic       pons_d;
	emit_t      e;
	logic       go_text;
	logic       ok;
	logic       done;

	// Work one byte through the matcher
	always_comb begin
		e       = '0;
		e.pons  = pons_q;
		held_d  = held_q;
		hc_d    = hc_q;
		aseq_d  = aseq_q;
		go_text = 1'b0;
		ok      = 1'b0;
		done    = 1'b0;

		if (aseq_q) begin
			// behind a sequence: look for variation selectors
			if (hc_d == 2'd0) begin
				if (data_byte == VsEF) begin
					held_d[0] = data_byte;
					hc_d = 2'd1;
				end else begin
					if (data_byte != SpaceByte)
						e = emit_put(e, SpaceByte);
					aseq_d  = 1'b0;
					go_text = 1'b1;
				end
			end else begin
				if (hc_d == 2'd1)
					ok = (data_byte == VsB8);
				else if (hc_d == 2'd2)
					ok = (data_byte == Vs8E) || (data_byte == Vs8F);
				if (ok && hc_d == 2'd2) begin
					for (int i = 0; i < 3; i++)
						if (2'(i) < hc_d) e = emit_put(e, held_d[i]);
					hc_d = 2'd0;
					e = emit_put(e, data_byte);
				end else if (ok) begin
					held_d[hc_d] = data_byte;
					hc_d = hc_d + 2'd1;
				end else begin
					// selector broken off: close the sequence, release the prefix
					e = emit_put(e, SpaceByte);
					for (int i = 0; i < 3; i++)
						if (2'(i) < hc_d) e = emit_put(e, held_d[i]);
					hc_d    = 2'd0;
					aseq_d  = 1'b0;
					go_text = 1'b1;
				end
			end
		end else if (hc_d == 2'd0) begin
			go_text = 1'b1;
		end else begin
			// partial match in ordinary text
			if (held_d[0] == LeadF0) begin
				case (hc_d)
					2'd1:    ok = (data_byte == Lead9F);
					2'd2:    ok = is_cont(data_byte);
					default: begin
						ok   = is_cont(data_byte);
						done = 1'b1;
					end
				endcase
			end else begin
				case (hc_d)
					2'd1:    ok = (data_byte >= SymLo) && (data_byte <= SymHi);
					2'd2: begin
						ok   = is_cont(data_byte);
						done = 1'b1;
					end
					default: ok = 1'b0;
				endcase
			end
			if (!ok) begin
				for (int i = 0; i < 3; i++)
					if (2'(i) < hc_d) e = emit_put(e, held_d[i]);
				hc_d    = 2'd0;
				go_text = 1'b1;
			end else if (done) begin
				if (e.pons)
					e = emit_put(e, SpaceByte);
				for (int i = 0; i < 3; i++)
					if (2'(i) < hc_d) e = emit_put(e, held_d[i]);
				hc_d = 2'd0;
				e = emit_put(e, data_byte);
				aseq_d = 1'b1;
			end else if (hc_d != 2'd3) begin
				held_d[hc_d] = data_byte;
				hc_d = hc_d + 2'd1;
			end
		end

		// plain byte with nothing held
		if (go_text) begin
			if (is_lead(data_byte)) begin
				held_d[0] = data_byte;
				hc_d = 2'd1;
			end else begin
				e = emit_put(e, data_byte);
			end
		end

		// end of text: flush what is held and start afresh
		if (end_of_text) begin
			if (hc_d != 2'd0) begin
				if (aseq_d)
					e = emit_put(e, SpaceByte);
				for (int i = 0; i < 3; i++)
					if (2'(i) < hc_d) e = emit_put(e, held_d[i]);
			end
			hc_d   = 2'd0;
			aseq_d = 1'b0;
			e.pons = 1'b0;
		end
		pons_d = e.pons;

		res.bytes = e.bytes;
		res.count = e.n;
		res.last  = end_of_text;
	end

	// Match state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hc_q   <= 2'd0;
			aseq_q <= 1'b0;
			pons_q <= 1'b0;
		end else if (advance) begin
			hc_q   <= hc_d;
			aseq_q <= aseq_d;
			pons_q <= pons_d;
		end
	end

	// Held bytes, read only below the count
	always_ff @(posedge clk) begin
		if (advance)
			held_q <= held_d;
	end

endmodule

@@ src/esp_outbuf.sv @@
// Result register: holds one input byte's bytes, sends one a cycle on m_tready.
module esp_outbuf import esp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  esp_result_t res,
	output logic        can_load,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // out_byte[7:0]
	output logic        m_tlast    // out_last
);

	logic [MaxOut-1:0][7:0] buf_q;
	logic [CntW-1:0]        cnt_q;
	logic                   last_q;
	logic                   take;

	assign m_tvalid = (cnt_q != '0);
	assign take     = m_tvalid && m_tready;
	assign m_tdata  = buf_q[0];
	assign m_tlast  = last_q && (cnt_q == CntW'(1));
	// free now, or its final byte goes out this cycle
	assign can_load = (cnt_q == '0) || ((cnt_q == CntW'(1)) && m_tready);

	// Count and end flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			last_q <= 1'b0;
		end else if (load) begin
			cnt_q  <= res.count;
			last_q <= res.last;
		end else if (take) begin
			cnt_q  <= cnt_q - CntW'(1);
		end
	end

	// Byte shift register, slot 0 on the bus
	always_ff @(posedge clk) begin
		if (load)
			buf_q <= res.bytes;
		else if (take)
			buf_q <= {8'h00, buf_q[MaxOut-1:1]};
	end

endmodule
